// ===== rtl/core/stfc_pkg.sv =====
// ---------------------------------------------------------------------------
// stfc_pkg: shared definitions for the segment table free/coalesce unit
// Widths, operation and status codes, cell commands and the saturating add
// used by every cell of the segment row.
// ---------------------------------------------------------------------------
`default_nettype none

package stfc_pkg;

   localparam int TABLE_DEPTH  = 64;
   localparam int ADDRESS_BITS = 16;
   localparam int ID_BITS      = 8;
   localparam int CNT_BITS     = $clog2(TABLE_DEPTH + 1);
   localparam int ENTRY_COUNT_BITS = 7;
   localparam int STATUS_BITS  = 2;

   localparam logic OP_APPEND  = 1'b0;
   localparam logic OP_RELEASE = 1'b1;

   localparam logic [STATUS_BITS-1:0] STATUS_DONE      = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_NOT_FOUND = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_FULL      = 2'd2;

   typedef struct packed {
      logic [ID_BITS-1:0]      seg_id;
      logic                    is_proc;
      logic [ADDRESS_BITS-1:0] base;
      logic [ADDRESS_BITS-1:0] size;
   } seg_entry_type;

   typedef enum logic [2:0] {
      CMD_NONE,
      CMD_APPEND,
      CMD_CAPTURE,
      CMD_ABSORB_RIGHT,
      CMD_TAKE_LEFT,
      CMD_CLEAR_PROC,
      CMD_SHIFT
   } cell_cmd_type;

   typedef struct packed {
      cell_cmd_type       cmd;
      logic [ID_BITS-1:0] id;
      seg_entry_type      entry;
   } cell_ctrl_type;

   typedef struct packed {
      logic found;
      logic prev_hole;
      logic next_hole;
   } row_status_type;

   function automatic logic [ADDRESS_BITS-1:0] sat_add(
      input logic [ADDRESS_BITS-1:0] a,
      input logic [ADDRESS_BITS-1:0] b
   );
      logic [ADDRESS_BITS:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      if (sum[ADDRESS_BITS]) begin
         return '1;
      end
      return sum[ADDRESS_BITS-1:0];
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/segment_table_free_coalesce_unit.sv =====
// ---------------------------------------------------------------------------
// segment_table_free_coalesce_unit: ordered segment table with coalescing
// Top level: a row of segment cells driven by a sequencer.
// ---------------------------------------------------------------------------
// An append transaction is taken in the idle state and its result appears in
// the next cycle. A release is taken, then matches the id across all cells
// at once, then looks at the neighbors and merges sizes; it ends there when
// the segment simply turns into a hole or is not found. When it merges with
// one neighboring hole, a shift step follows in which the row of cells shifts
// down by one slot to remove an entry; when it merges with holes on both
// sides, a second merge step and a second shift follow. The unit works on one
// transaction at a time, and takes a new one as soon as its result register
// is free or being read in the same cycle.
`default_nettype none

module segment_table_free_coalesce_unit (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   req_valid,
   output logic                                  req_stall,
   input  wire                                   req_opcode,
   input  wire  [stfc_pkg::ID_BITS-1:0]          req_segment_id,
   input  wire                                   req_is_process,
   input  wire  [stfc_pkg::ADDRESS_BITS-1:0]     req_base_address,
   input  wire  [stfc_pkg::ADDRESS_BITS-1:0]     req_segment_size,
   output logic                                  rsp_valid,
   input  wire                                   rsp_stall,
   output logic [stfc_pkg::STATUS_BITS-1:0]      rsp_status,
   output logic [stfc_pkg::ENTRY_COUNT_BITS-1:0] rsp_entry_count
);

   localparam int DEPTH = stfc_pkg::TABLE_DEPTH;

   stfc_pkg::cell_ctrl_type   ctrl;
   stfc_pkg::row_status_type  row_status;
   logic [stfc_pkg::CNT_BITS-1:0] count;

   stfc_pkg::seg_entry_type data  [DEPTH];
   stfc_pkg::seg_entry_type left_data  [DEPTH];
   stfc_pkg::seg_entry_type right_data [DEPTH];
   logic [DEPTH-1:0] mark;
   logic [DEPTH-1:0] left_mark;
   logic [DEPTH-1:0] right_mark;
   logic [DEPTH-1:0] valid;
   logic [DEPTH-1:0] wr_sel;
   logic [DEPTH-1:0] prev_vec;
   logic [DEPTH-1:0] next_vec;
   logic [DEPTH:0]   match_seen;

   assign match_seen[0] = 1'b0;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      assign valid[i]  = (stfc_pkg::CNT_BITS'(i) < count);
      assign wr_sel[i] = (stfc_pkg::CNT_BITS'(i) == count);

      if (i == 0) begin : g_first
         assign left_data[i] = '0;
         assign left_mark[i] = 1'b0;
      end else begin : g_mid_left
         assign left_data[i] = data[i-1];
         assign left_mark[i] = mark[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign right_data[i] = '0;
         assign right_mark[i] = 1'b0;
      end else begin : g_mid_right
         assign right_data[i] = data[i+1];
         assign right_mark[i] = mark[i+1];
      end

      // A hole right before the match, and a hole right after it.
      assign prev_vec[i] = right_mark[i] & valid[i] & ~data[i].is_proc;
      assign next_vec[i] = left_mark[i] & valid[i] & ~data[i].is_proc;

      stfc_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .valid      (valid[i]),
         .wr_sel     (wr_sel[i]),
         .before_in  (match_seen[i]),
         .left_data  (left_data[i]),
         .left_mark  (left_mark[i]),
         .right_data (right_data[i]),
         .right_mark (right_mark[i]),
         .before_out (match_seen[i+1]),
         .data       (data[i]),
         .mark       (mark[i])
      );
   end

   assign row_status.found     = |mark;
   assign row_status.prev_hole = |prev_vec;
   assign row_status.next_hole = |next_vec;

   stfc_ctrl u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_opcode       (req_opcode),
      .req_segment_id   (req_segment_id),
      .req_is_process   (req_is_process),
      .req_base_address (req_base_address),
      .req_segment_size (req_segment_size),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_entry_count  (rsp_entry_count),
      .row_status       (row_status),
      .ctrl             (ctrl),
      .count            (count)
   );

endmodule

`default_nettype wire

// ===== rtl/core/stfc_cell.sv =====
// ---------------------------------------------------------------------------
// stfc_cell: one slot of the segment row
// Holds one table entry plus its first-match and tail flags, and updates
// itself from the broadcast command and the entries of its two neighbors.
// ---------------------------------------------------------------------------
`default_nettype none

module stfc_cell (
   input  wire                    clock,
   input  wire                    reset,
   input  stfc_pkg::cell_ctrl_type ctrl,
   input  wire                    valid,
   input  wire                    wr_sel,
   input  wire                    before_in,
   input  stfc_pkg::seg_entry_type left_data,
   input  wire                    left_mark,
   input  stfc_pkg::seg_entry_type right_data,
   input  wire                    right_mark,
   output logic                   before_out,
   output stfc_pkg::seg_entry_type data,
   output logic                   mark
);

   stfc_pkg::seg_entry_type data_ff, data_in;
   logic mark_ff, mark_in;
   logic tail_ff, tail_in;
   logic hit;

   // The first-match chain ripples from cell 0 upward.
   assign hit        = valid && (data_ff.seg_id == ctrl.id);
   assign before_out = before_in | hit;

   always_comb begin
      data_in = data_ff;
      mark_in = mark_ff;
      tail_in = tail_ff;
      case (ctrl.cmd)
         stfc_pkg::CMD_APPEND: begin
            if (wr_sel) begin
               data_in = ctrl.entry;
            end
         end
         stfc_pkg::CMD_CAPTURE: begin
            mark_in = hit & ~before_in;
            tail_in = before_out;
         end
         stfc_pkg::CMD_ABSORB_RIGHT: begin
            if (right_mark) begin
               data_in.size = stfc_pkg::sat_add(data_ff.size, right_data.size);
            end
         end
         stfc_pkg::CMD_TAKE_LEFT: begin
            if (left_mark) begin
               data_in.base = left_data.base;
               data_in.size = stfc_pkg::sat_add(left_data.size, data_ff.size);
            end
         end
         stfc_pkg::CMD_CLEAR_PROC: begin
            if (mark_ff) begin
               data_in.is_proc = 1'b0;
            end
         end
         stfc_pkg::CMD_SHIFT: begin
            if (tail_ff) begin
               data_in = right_data;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      if (reset) begin
         mark_ff <= 1'b0;
         tail_ff <= 1'b0;
      end else begin
         mark_ff <= mark_in;
         tail_ff <= tail_in;
      end
   end

   assign data = data_ff;
   assign mark = mark_ff;

endmodule

`default_nettype wire

// ===== rtl/core/stfc_ctrl.sv =====
// ---------------------------------------------------------------------------
// stfc_ctrl: sequencer of the segment table
// Accepts transactions, keeps the entry count, steps the cell row through
// match, merge and shift commands, and holds the result register.
// ---------------------------------------------------------------------------
`default_nettype none

module stfc_ctrl (
   input  wire                                       clock,
   input  wire                                       reset,
   input  wire                                       req_valid,
   output logic                                      req_stall,
   input  wire                                       req_opcode,
   input  wire  [stfc_pkg::ID_BITS-1:0]              req_segment_id,
   input  wire                                       req_is_process,
   input  wire  [stfc_pkg::ADDRESS_BITS-1:0]         req_base_address,
   input  wire  [stfc_pkg::ADDRESS_BITS-1:0]         req_segment_size,
   output logic                                      rsp_valid,
   input  wire                                       rsp_stall,
   output logic [stfc_pkg::STATUS_BITS-1:0]          rsp_status,
   output logic [stfc_pkg::ENTRY_COUNT_BITS-1:0]     rsp_entry_count,
   input  stfc_pkg::row_status_type                  row_status,
   output stfc_pkg::cell_ctrl_type                   ctrl,
   output logic [stfc_pkg::CNT_BITS-1:0]             count
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MATCH,
      ST_EVAL,
      ST_SHIFT1,
      ST_ABSORB2,
      ST_SHIFT2
   } state_type;

   state_type state_ff, state_in;
   logic [stfc_pkg::CNT_BITS-1:0] count_ff, count_in;
   logic [stfc_pkg::ID_BITS-1:0] id_ff, id_in;
   logic second_ff, second_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [stfc_pkg::STATUS_BITS-1:0] status_ff, status_in;
   logic [stfc_pkg::ENTRY_COUNT_BITS-1:0] entry_count_ff, entry_count_in;
   logic accept;
   logic full;

   assign req_stall = (state_ff != ST_IDLE) || (rsp_valid_ff && rsp_stall);
   assign accept    = req_valid && !req_stall;
   assign full      = (count_ff == stfc_pkg::CNT_BITS'(stfc_pkg::TABLE_DEPTH));

   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      id_in          = id_ff;
      second_in      = second_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      status_in      = status_ff;
      entry_count_in = entry_count_ff;
      ctrl.cmd       = stfc_pkg::CMD_NONE;
      ctrl.id        = id_ff;
      ctrl.entry.seg_id  = req_segment_id;
      ctrl.entry.is_proc = req_is_process;
      ctrl.entry.base    = req_base_address;
      ctrl.entry.size    = req_segment_size;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_opcode == stfc_pkg::OP_APPEND) begin
                  rsp_valid_in = 1'b1;
                  if (full) begin
                     status_in      = stfc_pkg::STATUS_FULL;
                     entry_count_in = stfc_pkg::ENTRY_COUNT_BITS'(count_ff);
                  end else begin
                     ctrl.cmd       = stfc_pkg::CMD_APPEND;
                     count_in       = count_ff + stfc_pkg::CNT_BITS'(1);
                     status_in      = stfc_pkg::STATUS_DONE;
                     entry_count_in = stfc_pkg::ENTRY_COUNT_BITS'(count_in);
                  end
               end else begin
                  id_in    = req_segment_id;
                  state_in = ST_MATCH;
               end
            end
         end
         ST_MATCH: begin
            ctrl.cmd = stfc_pkg::CMD_CAPTURE;
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            if (!row_status.found) begin
               rsp_valid_in   = 1'b1;
               status_in      = stfc_pkg::STATUS_NOT_FOUND;
               entry_count_in = stfc_pkg::ENTRY_COUNT_BITS'(count_ff);
               state_in       = ST_IDLE;
            end else if (row_status.prev_hole) begin
               ctrl.cmd  = stfc_pkg::CMD_ABSORB_RIGHT;
               second_in = row_status.next_hole;
               state_in  = ST_SHIFT1;
            end else if (row_status.next_hole) begin
               ctrl.cmd  = stfc_pkg::CMD_TAKE_LEFT;
               second_in = 1'b0;
               state_in  = ST_SHIFT1;
            end else begin
               ctrl.cmd       = stfc_pkg::CMD_CLEAR_PROC;
               rsp_valid_in   = 1'b1;
               status_in      = stfc_pkg::STATUS_DONE;
               entry_count_in = stfc_pkg::ENTRY_COUNT_BITS'(count_ff);
               state_in       = ST_IDLE;
            end
         end
         ST_SHIFT1: begin
            ctrl.cmd = stfc_pkg::CMD_SHIFT;
            count_in = count_ff - stfc_pkg::CNT_BITS'(1);
            if (second_ff) begin
               state_in = ST_ABSORB2;
            end else begin
               rsp_valid_in   = 1'b1;
               status_in      = stfc_pkg::STATUS_DONE;
               entry_count_in = stfc_pkg::ENTRY_COUNT_BITS'(count_in);
               state_in       = ST_IDLE;
            end
         end
         ST_ABSORB2: begin
            // The hole that followed the released entry now sits at its slot.
            ctrl.cmd = stfc_pkg::CMD_ABSORB_RIGHT;
            state_in = ST_SHIFT2;
         end
         ST_SHIFT2: begin
            ctrl.cmd       = stfc_pkg::CMD_SHIFT;
            count_in       = count_ff - stfc_pkg::CNT_BITS'(1);
            rsp_valid_in   = 1'b1;
            status_in      = stfc_pkg::STATUS_DONE;
            entry_count_in = stfc_pkg::ENTRY_COUNT_BITS'(count_in);
            state_in       = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      id_ff          <= id_in;
      second_ff      <= second_in;
      status_ff      <= status_in;
      entry_count_ff <= entry_count_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_entry_count = entry_count_ff;
   assign count           = count_ff;

endmodule

`default_nettype wire

// ===== rtl/core/stfc_checker.sv =====
// ---------------------------------------------------------------------------
// stfc_checker: port-level checks for the segment table unit
// Watches the request and result channels of the top level over time.
// ---------------------------------------------------------------------------
`default_nettype none

module stfc_checker (
   input wire                                   clock,
   input wire                                   reset,
   input wire                                   req_valid,
   input wire                                   req_stall,
   input wire                                   req_opcode,
   input wire                                   rsp_valid,
   input wire                                   rsp_stall,
   input wire [stfc_pkg::STATUS_BITS-1:0]       rsp_status,
   input wire [stfc_pkg::ENTRY_COUNT_BITS-1:0]  rsp_entry_count
);

   // A result waiting on a stalled consumer holds its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_entry_count))
      else $error("stalled result changed");

   // An append transaction is answered in the following cycle.
   a_append_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_opcode == stfc_pkg::OP_APPEND |=> rsp_valid)
      else $error("append result late");

   // A release transaction keeps the unit busy, so the next transaction is held off.
   a_release_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_opcode == stfc_pkg::OP_RELEASE |=> req_stall)
      else $error("release did not hold off the next transaction");

   // A full report only comes with a full table.
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == stfc_pkg::STATUS_FULL
         |-> rsp_entry_count == stfc_pkg::ENTRY_COUNT_BITS'(stfc_pkg::TABLE_DEPTH))
      else $error("table full reported below capacity");

endmodule

bind segment_table_free_coalesce_unit stfc_checker u_stfc_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .req_opcode      (req_opcode),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_status      (rsp_status),
   .rsp_entry_count (rsp_entry_count)
);

`default_nettype wire

// ===== bench/segment_table_free_coalesce_unit_tb.sv =====
// ---------------------------------------------------------------------------
// segment_table_free_coalesce_unit_tb: self-checking bench for the segment table
// A scoreboard class keeps its own copy of the segment table and predicts the
// status and entry count of every accepted transaction. Directed transactions
// cover each coalescing rule. Random fill and drain phases follow, with idle
// gaps on both channels and one long receiver hold-off.
// ---------------------------------------------------------------------------

package segment_table_check_pkg;

   import stfc_pkg::*;

   class segment_table_scoreboard;
      seg_entry_type               segs[TABLE_DEPTH];
      int unsigned                 seg_count;
      logic [STATUS_BITS-1:0]      status_q[$];
      logic [ENTRY_COUNT_BITS-1:0] count_q[$];
      int unsigned                 errors;

      function new();
         seg_count = 0;
         errors    = 0;
      endfunction

      function logic [ADDRESS_BITS-1:0] merged_size(input logic [ADDRESS_BITS-1:0] a,
                                                    input logic [ADDRESS_BITS-1:0] b);
         logic [ADDRESS_BITS:0] total;
         total = {1'b0, a} + {1'b0, b};
         if (total > {ADDRESS_BITS{1'b1}}) begin
            return {ADDRESS_BITS{1'b1}};
         end
         return total[ADDRESS_BITS-1:0];
      endfunction

      function void remove_entry(input int unsigned pos);
         for (int unsigned k = pos; k + 1 < seg_count; k++) begin
            segs[k] = segs[k + 1];
         end
         seg_count--;
      endfunction

      function void note_request(input logic op, input logic [ID_BITS-1:0] id,
                                 input logic proc_mark,
                                 input logic [ADDRESS_BITS-1:0] seg_base,
                                 input logic [ADDRESS_BITS-1:0] seg_size);
         logic [STATUS_BITS-1:0] status;
         int                     hit;
         logic                   prev_hole;
         logic                   next_hole;
         status = STATUS_DONE;
         if (op == OP_APPEND) begin
            if (seg_count >= TABLE_DEPTH) begin
               status = STATUS_FULL;
            end else begin
               segs[seg_count] = '{seg_id: id, is_proc: proc_mark, base: seg_base,
                                   size: seg_size};
               seg_count++;
            end
         end else begin
            hit = -1;
            for (int k = 0; k < int'(seg_count) && hit < 0; k++) begin
               if (segs[k].seg_id == id) begin
                  hit = k;
               end
            end
            if (hit < 0) begin
               status = STATUS_NOT_FOUND;
            end else begin
               prev_hole = (hit > 0) && !segs[hit - 1].is_proc;
               next_hole = (hit + 1 < int'(seg_count)) && !segs[hit + 1].is_proc;
               if (prev_hole) begin
                  segs[hit - 1].size = merged_size(segs[hit - 1].size, segs[hit].size);
                  if (next_hole) begin
                     segs[hit - 1].size = merged_size(segs[hit - 1].size,
                                                      segs[hit + 1].size);
                     remove_entry(hit + 1);
                  end
                  remove_entry(hit);
               end else if (next_hole) begin
                  segs[hit + 1].size = merged_size(segs[hit].size, segs[hit + 1].size);
                  segs[hit + 1].base = segs[hit].base;
                  remove_entry(hit);
               end else begin
                  // A lone segment, process or hole, simply becomes a hole.
                  segs[hit].is_proc = 1'b0;
               end
            end
         end
         status_q = {status_q, status};
         count_q  = {count_q, ENTRY_COUNT_BITS'(seg_count)};
      endfunction

      function void check_response(input logic [STATUS_BITS-1:0] status,
                                   input logic [ENTRY_COUNT_BITS-1:0] count);
         logic [STATUS_BITS-1:0]      exp_status;
         logic [ENTRY_COUNT_BITS-1:0] exp_count;
         if (status_q.size() == 0) begin
            errors++;
            $display("%0t: unexpected transaction, status %0d entry_count %0d",
                     $time, status, count);
            return;
         end
         exp_status = status_q.pop_front();
         exp_count  = count_q.pop_front();
         if (status !== exp_status) begin
            errors++;
            $display("%0t: rsp_status expected %0d, got %0d", $time, exp_status,
                     status);
         end
         if (count !== exp_count) begin
            errors++;
            $display("%0t: rsp_entry_count expected %0d, got %0d", $time, exp_count,
                     count);
         end
      endfunction

      function int unsigned pending();
         return status_q.size();
      endfunction
   endclass

endpackage

module segment_table_free_coalesce_unit_tb;

   import stfc_pkg::*;
   import segment_table_check_pkg::*;

   localparam int unsigned CYCLE_LIMIT  = 1_000_000;
   localparam int unsigned RANDOM_ITEMS = 1900;
   localparam int unsigned HOLD_CYCLES  = 400;

   logic                        clock;
   logic                        reset;
   logic                        req_valid;
   logic                        req_stall;
   logic                        req_opcode;
   logic [ID_BITS-1:0]          req_segment_id;
   logic                        req_is_process;
   logic [ADDRESS_BITS-1:0]     req_base_address;
   logic [ADDRESS_BITS-1:0]     req_segment_size;
   logic                        rsp_valid;
   logic                        rsp_stall;
   logic [STATUS_BITS-1:0]      rsp_status;
   logic [ENTRY_COUNT_BITS-1:0] rsp_entry_count;

   segment_table_scoreboard sb = new();
   int unsigned             items_sent = 0;
   int unsigned             cycle_count = 0;
   bit                      hold_off_request = 1'b0;

   segment_table_free_coalesce_unit u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_opcode       (req_opcode),
      .req_segment_id   (req_segment_id),
      .req_is_process   (req_is_process),
      .req_base_address (req_base_address),
      .req_segment_size (req_segment_size),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_entry_count  (rsp_entry_count)
   );

   initial clock = 1'b0;
   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("segment_table_free_coalesce_unit: mismatch");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         sb.check_response(rsp_status, rsp_entry_count);
      end
   end

   // Offers one transaction and returns at the edge where it is accepted, with
   // valid still high so that a following transaction can go out back to back.
   task automatic send_segment_request(input logic op, input logic [ID_BITS-1:0] id,
                                       input logic proc_mark,
                                       input logic [ADDRESS_BITS-1:0] seg_base,
                                       input logic [ADDRESS_BITS-1:0] seg_size);
      req_valid        <= 1'b1;
      req_opcode       <= op;
      req_segment_id   <= id;
      req_is_process   <= proc_mark;
      req_base_address <= seg_base;
      req_segment_size <= seg_size;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      sb.note_request(op, id, proc_mark, seg_base, seg_size);
      items_sent++;
   endtask

   task automatic idle_sender();
      int unsigned r;
      int unsigned gap;
      r   = $urandom_range(0, 99);
      gap = 0;
      if (r >= 90) begin
         gap = $urandom_range(8, 40);
      end else if (r >= 55) begin
         gap = $urandom_range(1, 3);
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      do begin
         @(posedge clock);
      end while (sb.pending() != 0);
   endtask

   task automatic run_random_phase(input int unsigned n_items, input int unsigned append_pct);
      logic                    op;
      logic [ID_BITS-1:0]      id;
      logic                    proc_mark;
      logic [ADDRESS_BITS-1:0] seg_base;
      logic [ADDRESS_BITS-1:0] seg_size;
      int unsigned             pick;
      repeat (n_items) begin
         op = ($urandom_range(0, 99) < append_pct) ? OP_APPEND : OP_RELEASE;
         // Most releases name a segment that is in the table; small ids make
         // duplicates, so the first match rule gets exercised.
         if (op == OP_RELEASE && sb.seg_count > 0 && $urandom_range(0, 99) < 85) begin
            id = sb.segs[$urandom_range(0, sb.seg_count - 1)].seg_id;
         end else if ($urandom_range(0, 1) == 1) begin
            id = ID_BITS'($urandom_range(0, 15));
         end else begin
            id = ID_BITS'($urandom_range(0, 255));
         end
         proc_mark = ($urandom_range(0, 99) < 65);
         seg_base  = ADDRESS_BITS'($urandom_range(0, 16'hFFFF));
         pick      = $urandom_range(0, 9);
         if (pick < 4) begin
            seg_size = ADDRESS_BITS'($urandom_range(0, 255));
         end else if (pick < 7) begin
            seg_size = ADDRESS_BITS'($urandom_range(0, 16'hFFFF));
         end else begin
            seg_size = ADDRESS_BITS'($urandom_range(16'hC000, 16'hFFFF));
         end
         send_segment_request(op, id, proc_mark, seg_base, seg_size);
         idle_sender();
      end
   endtask

   // Receiver: calm stretches, short stalls, occasional long ones, and a single
   // long hold-off on request so that the unit backs up into its input.
   initial begin
      int unsigned calm_left;
      int unsigned stall_left;
      int unsigned hold_left;
      int unsigned r;
      bit          hold_taken;
      calm_left  = 0;
      stall_left = 0;
      hold_left  = 0;
      hold_taken = 1'b0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_request && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left  = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else if (calm_left > 0) begin
            rsp_stall <= 1'b0;
            calm_left--;
         end else if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 50) begin
               calm_left = $urandom_range(4, 40);
            end else if (r < 92) begin
               stall_left = $urandom_range(1, 3);
            end else begin
               stall_left = $urandom_range(10, 50);
            end
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_opcode       <= OP_APPEND;
      req_segment_id   <= '0;
      req_is_process   <= 1'b0;
      req_base_address <= '0;
      req_segment_size <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed part, starting from an empty table.
      send_segment_request(OP_RELEASE, 8'd5,   1'b1, 16'h0000, 16'h0000);
      send_segment_request(OP_APPEND,  8'd1,   1'b1, 16'h0000, 16'hFFFF);
      send_segment_request(OP_APPEND,  8'd2,   1'b0, 16'hFFFF, 16'hF000);
      idle_sender();
      send_segment_request(OP_APPEND,  8'd3,   1'b1, 16'h1000, 16'h2000);
      send_segment_request(OP_APPEND,  8'd4,   1'b0, 16'h3000, 16'h0100);
      send_segment_request(OP_APPEND,  8'hFF,  1'b1, 16'h5555, 16'h0000);
      send_segment_request(OP_APPEND,  8'd0,   1'b0, 16'hAAAA, 16'hFFFF);
      // Holes on both sides, with a saturating merge.
      send_segment_request(OP_RELEASE, 8'd3,   1'b0, 16'hFFFF, 16'hFFFF);
      // Only a hole after the first entry.
      send_segment_request(OP_RELEASE, 8'd1,   1'b1, 16'h0000, 16'h0000);
      send_segment_request(OP_RELEASE, 8'hFF,  1'b0, 16'h0000, 16'h0000);
      // The single remaining hole is released again and stays a hole.
      send_segment_request(OP_RELEASE, 8'd2,   1'b0, 16'h0000, 16'h0000);
      send_segment_request(OP_APPEND,  8'd7,   1'b1, 16'h0010, 16'h0020);
      send_segment_request(OP_APPEND,  8'd7,   1'b1, 16'h0030, 16'h0040);
      send_segment_request(OP_RELEASE, 8'd7,   1'b0, 16'h0000, 16'h0000);
      send_segment_request(OP_APPEND,  8'd9,   1'b1, 16'h0070, 16'h0008);
      send_segment_request(OP_RELEASE, 8'd9,   1'b0, 16'h0000, 16'h0000);
      send_segment_request(OP_RELEASE, 8'd7,   1'b0, 16'h0000, 16'h0000);
      send_segment_request(OP_APPEND,  8'h80,  1'b0, 16'h8000, 16'h0001);
      send_segment_request(OP_RELEASE, 8'h80,  1'b1, 16'h0000, 16'h0000);
      send_segment_request(OP_APPEND,  8'hAA,  1'b1, 16'h00AA, 16'h0055);
      send_segment_request(OP_APPEND,  8'h55,  1'b1, 16'h0100, 16'h00AA);
      send_segment_request(OP_RELEASE, 8'h55,  1'b0, 16'h0000, 16'h0000);
      send_segment_request(OP_RELEASE, 8'hAA,  1'b0, 16'h0000, 16'h0000);
      drain_results();

      // Random part: fill and drain phases alternate so the table keeps
      // reaching full and collapsing back through merges.
      for (int p = 0; items_sent < RANDOM_ITEMS; p++) begin
         if (p == 2) begin
            hold_off_request = 1'b1;
         end
         run_random_phase($urandom_range(60, 240), (p % 2 == 0) ? 75 : 20);
         if (p % 3 == 2) begin
            drain_results();
         end
      end

      drain_results();
      repeat (20) @(posedge clock);
      if (sb.errors == 0) begin
         $display("segment_table_free_coalesce_unit: match");
      end else begin
         $display("segment_table_free_coalesce_unit: mismatch");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/core/stfc_pkg.sv
rtl/core/stfc_cell.sv
rtl/core/stfc_ctrl.sv
rtl/core/segment_table_free_coalesce_unit.sv
rtl/core/stfc_checker.sv
bench/segment_table_free_coalesce_unit_tb.sv
